>>> hdl/bspd_pkg.sv
// Package for the BMP stream pixel decoder.
// Holds the channel payload types, phase encoding and format constants.
// No dependencies.
package bspd_pkg;

  localparam int PIX_W     = 13;
  localparam int ORIGIN_W  = 12;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;

  localparam logic [1:0] ST_PIXEL     = 2'd0;
  localparam logic [1:0] ST_BAD_SIG   = 2'd1;
  localparam logic [1:0] ST_BAD_DEPTH = 2'd2;
  localparam logic [1:0] ST_TOO_LARGE = 2'd3;

  localparam logic [7:0] SIG_B = 8'h42;
  localparam logic [7:0] SIG_M = 8'h4d;

  localparam logic [5:0] OFF_SIG0     = 6'h00;
  localparam logic [5:0] OFF_SIG1     = 6'h01;
  localparam logic [5:0] OFF_WIDTH    = 6'h12;
  localparam logic [5:0] OFF_HEIGHT   = 6'h16;
  localparam logic [5:0] OFF_DEPTH_LO = 6'h1c;
  localparam logic [5:0] OFF_DEPTH_HI = 6'h1d;
  localparam logic [5:0] OFF_PIXELS   = 6'h36;

  localparam logic [15:0] DEPTH_24 = 16'd24;
  localparam logic [15:0] DEPTH_32 = 16'd32;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_PIXELS = 3'b010,
    PH_DONE   = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       start_of_file;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic [31:0]      argb_color;
    logic             last_pixel;
  } out_item_t;

  typedef struct packed {
    logic [ORIGIN_W-1:0] x;
    logic [ORIGIN_W-1:0] y;
  } origin_t;

endpackage

>>> hdl/bmp_stream_pixel_decoder_unit.sv
// A byte transfers into the input register, is decoded from there and its result, if any,
// is registered in the output register.
// Throughput: one byte per cycle; a held byte is decoded only when the output register is
// empty or its result transfers in that cycle, so the input holds while both are full.
// Reset (rst_n low, synchronous): parser back to the header phase, all counters, captured
// header fields and origin registers cleared, both pipeline registers emptied.
module bmp_stream_pixel_decoder_unit #(
  parameter int MAX_DIM = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bspd_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bspd_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bspd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bspd_pkg::ORIGIN_W-1:0]  cfg_wdata
);

  logic                in_vld_r;
  bspd_pkg::in_item_t  in_data_r;
  logic                out_vld_r;
  bspd_pkg::out_item_t out_data_r;
  logic                fire;
  logic                res_vld;
  bspd_pkg::out_item_t res;
  bspd_pkg::origin_t   origin;

  bspd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .origin    (origin)
  );

  bspd_core #(
    .MAX_DIM (MAX_DIM)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (fire),
    .in_item (in_data_r),
    .origin  (origin),
    .res_vld (res_vld),
    .res     (res)
  );

  assign fire      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !fire;
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (fire) begin
        out_vld_r <= res_vld;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_data_r <= in_data;
    end
    if (fire && res_vld) begin
      out_data_r <= res;
    end
  end

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !fire |=> in_vld_r && $stable(in_data_r))
    else $error("held input byte lost");

  a_res_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_vld |=> out_valid)
    else $error("decoded result not presented");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

>>> hdl/bspd_cfg.sv
// Origin registers written through the configuration channel.
// Depends on bspd_pkg.
module bspd_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bspd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bspd_pkg::ORIGIN_W-1:0]      cfg_wdata,
  output bspd_pkg::origin_t                  origin
);

  bspd_pkg::origin_t origin_r;

  assign cfg_ready = 1'b1;
  assign origin    = origin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        bspd_pkg::CFG_ORIGIN_X: origin_r.x <= cfg_wdata;
        bspd_pkg::CFG_ORIGIN_Y: origin_r.y <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/bspd_core.sv
// Header parser and pixel assembler: one file byte per step, at most one result.
// Depends on bspd_pkg.
module bspd_core #(
  parameter int MAX_DIM = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  bspd_pkg::in_item_t  in_item,
  input  bspd_pkg::origin_t   origin,
  output logic                res_vld,
  output bspd_pkg::out_item_t res
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int PW    = bspd_pkg::PIX_W;

  bspd_pkg::phase_t ph_r, ph_nxt, ph_e;
  logic [5:0]       off_r, off_nxt, off_e;
  logic [31:0]      w_r, w_nxt, w_e;
  logic [31:0]      h_r, h_nxt, h_e;
  logic [15:0]      dep_r, dep_nxt, dep_e;
  logic [DIM_W-1:0] cc_r, cc_nxt, cc_e;
  logic [DIM_W-1:0] rc_r, rc_nxt, rc_e;
  logic [1:0]       bip_r, bip_nxt, bip_e;
  logic [23:0]      pp_r, pp_nxt, pp_e;
  logic [1:0]       pad_r, pad_nxt, pad_e;

  logic [7:0]       b;
  logic [31:0]      mw, mh;
  logic [DIM_W-1:0] mw_n, mh_n;
  logic [1:0]       w_idx, h_idx;
  logic [15:0]      dep_full;
  logic             bpp4;
  logic [23:0]      pp_upd;
  logic [7:0]       alpha;
  logic             more_bytes;
  logic [PW-1:0]    xs, ys;
  logic             col_last, row_last;

  assign b        = in_item.byte_value;
  assign mw       = w_e[31] ? (32'd0 - w_e) : w_e;
  assign mh       = h_e[31] ? (32'd0 - h_e) : h_e;
  assign mw_n     = mw[DIM_W-1:0];
  assign mh_n     = mh[DIM_W-1:0];
  assign w_idx    = 2'(off_e - bspd_pkg::OFF_WIDTH);
  assign h_idx    = 2'(off_e - bspd_pkg::OFF_HEIGHT);
  assign dep_full = {b, dep_e[7:0]};
  assign bpp4     = (dep_e == bspd_pkg::DEPTH_32);
  assign alpha    = (bip_e == 2'd3) ? b : 8'd0;
  assign more_bytes = bpp4 ? (bip_e != 2'd3) : (bip_e < 2'd2);
  assign xs = w_e[31] ? (PW'(mw_n) - PW'(cc_e) - PW'(1)) : PW'(cc_e);
  assign ys = h_e[31] ? PW'(rc_e) : (PW'(mh_n) - PW'(rc_e) - PW'(1));
  assign col_last = ((DIM_W+1)'(cc_e) + (DIM_W+1)'(1)) >= (DIM_W+1)'(mw_n);
  assign row_last = ((DIM_W+1)'(rc_e) + (DIM_W+1)'(1)) >= (DIM_W+1)'(mh_n);

  always_comb begin
    case (bip_e)
      2'd0:    pp_upd = pp_e | {16'd0, b};
      2'd1:    pp_upd = pp_e | {8'd0, b, 8'd0};
      2'd2:    pp_upd = pp_e | {b, 16'd0};
      default: pp_upd = pp_e;
    endcase
  end

  always_comb begin
    ph_e  = ph_r;
    off_e = off_r;
    w_e   = w_r;
    h_e   = h_r;
    dep_e = dep_r;
    cc_e  = cc_r;
    rc_e  = rc_r;
    bip_e = bip_r;
    pp_e  = pp_r;
    pad_e = pad_r;
    if (in_item.start_of_file) begin
      ph_e  = bspd_pkg::PH_HEADER;
      off_e = '0;
      w_e   = '0;
      h_e   = '0;
      dep_e = '0;
      cc_e  = '0;
      rc_e  = '0;
      bip_e = '0;
      pp_e  = '0;
      pad_e = '0;
    end
  end

  always_comb begin
    ph_nxt  = ph_e;
    off_nxt = off_e;
    w_nxt   = w_e;
    h_nxt   = h_e;
    dep_nxt = dep_e;
    cc_nxt  = cc_e;
    rc_nxt  = rc_e;
    bip_nxt = bip_e;
    pp_nxt  = pp_e;
    pad_nxt = pad_e;
    res_vld = 1'b0;
    res     = '0;
    case (ph_e)
      bspd_pkg::PH_HEADER: begin
        if ((off_e == bspd_pkg::OFF_SIG0 && b != bspd_pkg::SIG_B) ||
            (off_e == bspd_pkg::OFF_SIG1 && b != bspd_pkg::SIG_M)) begin
          res_vld    = 1'b1;
          res.status = bspd_pkg::ST_BAD_SIG;
          ph_nxt     = bspd_pkg::PH_DONE;
        end else if (off_e == bspd_pkg::OFF_DEPTH_HI &&
                     dep_full != bspd_pkg::DEPTH_24 && dep_full != bspd_pkg::DEPTH_32) begin
          dep_nxt    = dep_full;
          res_vld    = 1'b1;
          res.status = bspd_pkg::ST_BAD_DEPTH;
          ph_nxt     = bspd_pkg::PH_DONE;
        end else if (off_e == bspd_pkg::OFF_DEPTH_HI &&
                     (mw > 32'(MAX_DIM) || mh > 32'(MAX_DIM))) begin
          dep_nxt    = dep_full;
          res_vld    = 1'b1;
          res.status = bspd_pkg::ST_TOO_LARGE;
          ph_nxt     = bspd_pkg::PH_DONE;
        end else begin
          if (off_e >= bspd_pkg::OFF_WIDTH && off_e < bspd_pkg::OFF_HEIGHT) begin
            w_nxt[{w_idx, 3'b000} +: 8] = b;
          end
          if (off_e >= bspd_pkg::OFF_HEIGHT && off_e < bspd_pkg::OFF_HEIGHT + 6'd4) begin
            h_nxt[{h_idx, 3'b000} +: 8] = b;
          end
          if (off_e == bspd_pkg::OFF_DEPTH_LO) begin
            dep_nxt[7:0] = b;
          end
          if (off_e == bspd_pkg::OFF_DEPTH_HI) begin
            dep_nxt = dep_full;
          end
          if (off_e + 6'd1 >= bspd_pkg::OFF_PIXELS) begin
            ph_nxt  = (mw == 32'd0 || mh == 32'd0) ? bspd_pkg::PH_DONE : bspd_pkg::PH_PIXELS;
            cc_nxt  = '0;
            rc_nxt  = '0;
            bip_nxt = '0;
            pp_nxt  = '0;
            pad_nxt = '0;
          end else begin
            off_nxt = off_e + 6'd1;
          end
        end
      end
      bspd_pkg::PH_PIXELS: begin
        if (pad_e != 2'd0) begin
          pad_nxt = pad_e - 2'd1;
        end else if (more_bytes) begin
          pp_nxt  = pp_upd;
          bip_nxt = bip_e + 2'd1;
        end else begin
          res_vld        = 1'b1;
          res.status     = bspd_pkg::ST_PIXEL;
          res.pixel_x    = xs + PW'(origin.x);
          res.pixel_y    = ys + PW'(origin.y);
          res.argb_color = {alpha, pp_upd};
          bip_nxt        = '0;
          pp_nxt         = '0;
          if (col_last) begin
            cc_nxt = '0;
            if (row_last) begin
              res.last_pixel = 1'b1;
              ph_nxt         = bspd_pkg::PH_DONE;
            end else begin
              rc_nxt  = rc_e + DIM_W'(1);
              pad_nxt = bpp4 ? 2'd0 : mw[1:0];
            end
          end else begin
            cc_nxt = cc_e + DIM_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= bspd_pkg::PH_HEADER;
      off_r <= '0;
      w_r   <= '0;
      h_r   <= '0;
      dep_r <= '0;
      cc_r  <= '0;
      rc_r  <= '0;
      bip_r <= '0;
      pp_r  <= '0;
      pad_r <= '0;
    end else if (step_en) begin
      ph_r  <= ph_nxt;
      off_r <= off_nxt;
      w_r   <= w_nxt;
      h_r   <= h_nxt;
      dep_r <= dep_nxt;
      cc_r  <= cc_nxt;
      rc_r  <= rc_nxt;
      bip_r <= bip_nxt;
      pp_r  <= pp_nxt;
      pad_r <= pad_nxt;
    end
  end

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res_vld && res.last_pixel |=> ph_r == bspd_pkg::PH_DONE)
    else $error("last pixel did not end the image");

  a_pad_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pad_r != 2'd0 |-> dep_r == bspd_pkg::DEPTH_24)
    else $error("row padding pending on a 32-bit image");

  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(ph_r))
    else $error("parser phase not one-hot");

endmodule
